@@ design/modular_exponentiation_defines.svh @@
// Assertion macros shared by the modular exponentiation RTL.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define MEXP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication
`define MEXP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define MEXP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MEXP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ design/mexp_pkg.sv @@
// Shared constants for the modular exponentiation block.
`timescale 1ns / 1ps
package mexp_pkg;

    localparam int FieldW         = 63;   // base and exponent port width
    localparam int PowerW         = 30;   // residue width
    localparam int ExpBitsDefault = 63;
    localparam int MulW           = 32;   // shared multiplier operand width
    localparam int MuW            = PowerW + 1;

    localparam logic [63:0] PrimeModL  = 64'd1000000007;
    localparam logic [63:0] BarrettMuL = (64'd1 << (2 * PowerW)) / PrimeModL;
    // 2^30 mod P, the weight of one 30-bit base digit
    localparam logic [63:0] RadixResL  = (64'd1 << PowerW) % PrimeModL;

    localparam logic [PowerW-1:0] PrimeMod  = PrimeModL[PowerW-1:0];
    localparam logic [MuW-1:0]    BarrettMu = BarrettMuL[MuW-1:0];
    localparam logic [PowerW-1:0] RadixRes  = RadixResL[PowerW-1:0];

endpackage

@@ design/mexp_mulmod.sv @@
// Modular multiplier: one shared 32x32 multiplier stepped through a Barrett reduction.
`timescale 1ns / 1ps
module mexp_mulmod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mexp_pkg::PowerW-1:0] i_a,
    input  logic [mexp_pkg::PowerW-1:0] i_b,
    output logic                        o_done,
    output logic [mexp_pkg::PowerW-1:0] o_res
);
    import mexp_pkg::*;

    localparam int XW = 2 * PowerW;
    localparam logic [MulW-1:0] P1 = MulW'(PrimeMod);
    localparam logic [MulW-1:0] P2 = MulW'({PrimeMod, 1'b0});

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_EST  = 6'b000100,
        S_QP   = 6'b001000,
        S_SUB  = 6'b010000,
        S_FIX  = 6'b100000
    } t_mm_state;

    t_mm_state           r_state, n_state;
    logic                r_done,  n_done;
    logic [PowerW-1:0]   r_a,     n_a;
    logic [PowerW-1:0]   r_b,     n_b;
    logic [MulW-1:0]     r_x,     n_x;
    logic [2*MulW-1:0]   r_prod,  n_prod;
    logic [MulW-1:0]     r_rem,   n_rem;
    logic [PowerW-1:0]   r_res,   n_res;

    logic [MulW-1:0]     mul_a, mul_b;
    logic [2*MulW-1:0]   mul_p;

    // operand select for the single multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MUL: begin
                mul_a = MulW'(r_a);
                mul_b = MulW'(r_b);
            end
            S_EST: begin
                // x >> 29 times mu
                mul_a = MulW'(r_prod[XW-1:PowerW-1]);
                mul_b = MulW'(BarrettMu);
            end
            S_QP: begin
                // q = (x >> 29) * mu >> 31
                mul_a = MulW'(r_prod[XW+1:PowerW+1]);
                mul_b = P1;
            end
            default: ;
        endcase
    end

    assign mul_p = (2*MulW)'(mul_a) * (2*MulW)'(mul_b);

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_a     = r_a;
        n_b     = r_b;
        n_x     = r_x;
        n_prod  = r_prod;
        n_rem   = r_rem;
        n_res   = r_res;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_a     = i_a;
                    n_b     = i_b;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = mul_p;
                n_state = S_EST;
            end
            S_EST: begin
                n_x     = r_prod[MulW-1:0];
                n_prod  = mul_p;
                n_state = S_QP;
            end
            S_QP: begin
                n_prod  = mul_p;
                n_state = S_SUB;
            end
            S_SUB: begin
                // remainder is below 3P, so 32 bits hold it exactly
                n_rem   = r_x - r_prod[MulW-1:0];
                n_state = S_FIX;
            end
            S_FIX: begin
                if (r_rem >= P2) begin
                    n_res = PowerW'(r_rem - P2);
                end else if (r_rem >= P1) begin
                    n_res = PowerW'(r_rem - P1);
                end else begin
                    n_res = PowerW'(r_rem);
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_x    <= n_x;
        r_prod <= n_prod;
        r_rem  <= n_rem;
        r_res  <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

@@ design/modular_exponentiation.sv @@
// Top level: base^exponent mod 1000000007 by right-to-left square-and-multiply.
//
// Command channel: hold i_base/i_exponent and raise start; the word is taken
// at a clock edge where start is high and busy is low. busy stays high until
// the result is issued.
// Result channel: o_power is valid for exactly one cycle while o_valid is
// high; the receiver cannot stall, so the word must be captured then.
// Sequence: the base is folded mod the prime 30 bits at a time, two passes
// through the shared Barrett multiplier, before the first exponent bit.
// Each exponent bit then costs a square only (bit clear) or a multiply
// and a square (bit set), both on the shared Barrett multiplier; the scan
// stops after the highest set bit, skipping the last square.
// One word is in flight at a time. busy drops in the cycle o_valid is high,
// so the next command can be taken there.
// Reset (synchronous, active low) returns both sequencers to idle and clears
// o_valid; no result is issued for a word that was in flight.
`timescale 1ns / 1ps
`include "modular_exponentiation_defines.svh"
module modular_exponentiation #(
    parameter int EXP_BITS = mexp_pkg::ExpBitsDefault
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [mexp_pkg::FieldW-1:0] i_base,
    input  logic [mexp_pkg::FieldW-1:0] i_exponent,
    output logic                        o_valid,
    output logic [mexp_pkg::PowerW-1:0] o_power
);
    import mexp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RED   = 5'b00010,
        S_CHECK = 5'b00100,
        S_MULW  = 5'b01000,
        S_SQW   = 5'b10000
    } t_state;

    t_state               r_state,   n_state;
    logic                 r_valid,   n_valid;
    logic [2*PowerW-1:0]  r_base_sh, n_base_sh;
    logic                 r_cnt,     n_cnt;
    logic [PowerW-1:0]    r_b,       n_b;
    logic [PowerW-1:0]    r_acc,     n_acc;
    logic [EXP_BITS-1:0]  r_exp,     n_exp;
    logic [PowerW-1:0]    r_power,   n_power;

    logic                 mm_start;
    logic [PowerW-1:0]    mm_a;
    logic [PowerW-1:0]    mm_b;
    logic                 mm_done;
    logic [PowerW-1:0]    mm_res;
    logic                 mm_wait;

    logic [PowerW-1:0]    red_dig;
    logic [PowerW-1:0]    red_d;
    logic [PowerW:0]      red_t;
    logic [PowerW:0]      red_n;

    // fold: residue * 2^30 (from the multiplier) plus the next 30-bit digit
    assign red_dig = r_base_sh[2*PowerW-1:PowerW];
    assign red_d   = (red_dig >= PrimeMod) ? red_dig - PrimeMod : red_dig;
    assign red_t   = {1'b0, mm_res} + {1'b0, red_d};
    assign red_n = (red_t >= {1'b0, PrimeMod}) ? red_t - {1'b0, PrimeMod} : red_t;

    mexp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mm_start),
        .i_a     (mm_a),
        .i_b     (mm_b),
        .o_done  (mm_done),
        .o_res   (mm_res)
    );

    always_comb begin
        n_state   = r_state;
        n_valid   = 1'b0;
        n_base_sh = r_base_sh;
        n_cnt     = r_cnt;
        n_b       = r_b;
        n_acc     = r_acc;
        n_exp     = r_exp;
        n_power   = r_power;
        mm_start  = 1'b0;
        mm_a      = r_b;
        mm_b      = r_b;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_base_sh = i_base[2*PowerW-1:0];
                    n_cnt     = 1'b0;
                    n_acc     = PowerW'(1);
                    n_exp     = i_exponent[EXP_BITS-1:0];
                    // top three base bits times 2^30 mod P
                    mm_start  = 1'b1;
                    mm_a      = PowerW'(i_base[FieldW-1:2*PowerW]);
                    mm_b      = RadixRes;
                    n_state   = S_RED;
                end
            end
            S_RED: begin
                if (mm_done) begin
                    n_b       = red_n[PowerW-1:0];
                    n_base_sh = r_base_sh << PowerW;
                    if (!r_cnt) begin
                        n_cnt    = 1'b1;
                        mm_start = 1'b1;
                        mm_a     = red_n[PowerW-1:0];
                        mm_b     = RadixRes;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (r_exp == '0) begin
                    n_valid = 1'b1;
                    n_power = r_acc;
                    n_state = S_IDLE;
                end else begin
                    mm_start = 1'b1;
                    if (r_exp[0]) begin
                        mm_a    = r_acc;
                        n_state = S_MULW;
                    end else begin
                        n_state = S_SQW;
                    end
                end
            end
            S_MULW: begin
                if (mm_done) begin
                    n_acc = mm_res;
                    if ((r_exp >> 1) == '0) begin
                        // last set bit: the square would go unused
                        n_valid = 1'b1;
                        n_power = mm_res;
                        n_state = S_IDLE;
                    end else begin
                        mm_start = 1'b1;
                        n_state  = S_SQW;
                    end
                end
            end
            S_SQW: begin
                if (mm_done) begin
                    n_b     = mm_res;
                    n_exp   = r_exp >> 1;
                    n_state = S_CHECK;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base_sh <= n_base_sh;
        r_cnt     <= n_cnt;
        r_b       <= n_b;
        r_acc     <= n_acc;
        r_exp     <= n_exp;
        r_power   <= n_power;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_power = r_power;

    assign mm_wait = (r_state == S_RED) || (r_state == S_MULW) || (r_state == S_SQW);

    `MEXP_ASSERT_IMP(a_power_range, i_clk, i_rst_n, o_valid, o_power < PrimeMod)
    `MEXP_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, start && !busy, busy)
    `MEXP_ASSERT_NXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid)
    `MEXP_ASSERT_IMP(a_mm_done_expected, i_clk, i_rst_n, mm_done, mm_wait)

endmodule
